[src/stq_pkg.sv]
`timescale 1ns / 1ps

package stq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 16;

    localparam int CMD_W   = 2;
    localparam int TGT_W   = 16;
    localparam int TIME_W  = 32;
    localparam int RPT_W   = 16;
    localparam int REPS_W  = 17;
    localparam int COUNT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 2'd0,
        CMD_DELETE   = 2'd1,
        CMD_CONTAINS = 2'd2,
        CMD_CLEAR    = 2'd3
    } cmd_t;

    // operation broadcast to every cell of the row
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_MARK,
        CELL_INSERT,
        CELL_SWAP
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     phase;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_EXEC,
        ST_SWAP,
        ST_TALLY,
        ST_DONE
    } state_t;

endpackage

[src/stq_cell.sv]
`timescale 1ns / 1ps

module stq_cell #(
    parameter int Index = 0,
    parameter int IdW   = 16,
    parameter int CntW  = 5
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  stq_pkg::cell_ctrl_t                ctrl,
    input  logic [CntW-1:0]                    count,
    input  logic [IdW-1:0]                     key_target,
    input  logic [stq_pkg::TIME_W-1:0]         key_time,
    input  logic signed [stq_pkg::REPS_W-1:0]  key_reps,
    input  logic [IdW-1:0]                     prev_target,
    input  logic [stq_pkg::TIME_W-1:0]         prev_time,
    input  logic signed [stq_pkg::REPS_W-1:0]  prev_reps,
    input  logic                               prev_keep,
    input  logic                               prev_take,
    input  logic [IdW-1:0]                     next_target,
    input  logic [stq_pkg::TIME_W-1:0]         next_time,
    input  logic signed [stq_pkg::REPS_W-1:0]  next_reps,
    input  logic                               next_keep,
    output logic [IdW-1:0]                     cell_target,
    output logic [stq_pkg::TIME_W-1:0]         cell_time,
    output logic signed [stq_pkg::REPS_W-1:0]  cell_reps,
    output logic                               keep,
    output logic                               match,
    output logic                               take
);

    import stq_pkg::*;

    localparam logic IsOdd = ((Index % 2) == 1);

    logic [IdW-1:0]            target_reg, target_next;
    logic [TIME_W-1:0]         time_reg, time_next;
    logic signed [REPS_W-1:0]  reps_reg, reps_next;
    logic                      keep_reg, keep_next;
    logic                      match_reg, match_next;
    logic                      occupied;

    assign occupied = (CntW'(Index) < count);
    // insert point: first held entry not earlier than the key, or the tail
    assign take     = occupied ? (key_time <= time_reg) : 1'b1;

    always_comb
    begin
        target_next = target_reg;
        time_next   = time_reg;
        reps_next   = reps_reg;
        keep_next   = keep_reg;
        match_next  = match_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
            end
            CELL_MARK:
            begin
                match_next = occupied && (target_reg == key_target);
                keep_next  = occupied && (target_reg != key_target);
            end
            CELL_INSERT:
            begin
                if (take)
                begin
                    if (prev_take)
                    begin
                        target_next = prev_target;
                        time_next   = prev_time;
                        reps_next   = prev_reps;
                    end
                    else
                    begin
                        target_next = key_target;
                        time_next   = key_time;
                        reps_next   = key_reps;
                    end
                end
            end
            CELL_SWAP:
            begin
                if (ctrl.phase == IsOdd)
                begin
                    // lower member of the pair: pull a kept word down into a hole
                    if (!keep_reg && next_keep)
                    begin
                        target_next = next_target;
                        time_next   = next_time;
                        reps_next   = next_reps;
                        keep_next   = 1'b1;
                    end
                end
                else
                begin
                    // upper member: hand the word down, become the hole
                    if (!prev_keep && keep_reg)
                    begin
                        target_next = prev_target;
                        time_next   = prev_time;
                        reps_next   = prev_reps;
                        keep_next   = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        time_reg   <= time_next;
        reps_reg   <= reps_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg  <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            keep_reg  <= keep_next;
            match_reg <= match_next;
        end
    end

    assign cell_target = target_reg;
    assign cell_time   = time_reg;
    assign cell_reps   = reps_reg;
    assign keep        = keep_reg;
    assign match       = match_reg;

endmodule

[src/sorted_timer_queue_unit.sv]
`timescale 1ns / 1ps
// Sequence: insert, contains and clear pass through the mark, execute and deliver states
//   after acceptance; delete adds odd-even compaction, one step per cell, and a tally state.
// A new command word is accepted only in the idle state, so each word runs to the end of
//   its sequence first; the deliver state waits while a held result word is stalled.
// Reset (rst_n, asynchronous, active low) empties the queue and the output register;
//   entry payload is not cleared and is only read below the entry count.

module sorted_timer_queue_unit #(
    parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = stq_pkg::ID_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [stq_pkg::CMD_W-1:0]          command,
    input  logic [stq_pkg::TGT_W-1:0]          target_id,
    input  logic [stq_pkg::TIME_W-1:0]         due_time,
    input  logic [stq_pkg::RPT_W-1:0]          repeat_count,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               status,
    output logic                               found,
    output logic [stq_pkg::COUNT_W-1:0]        entry_count,
    output logic                               head_valid,
    output logic [stq_pkg::TGT_W-1:0]          head_target,
    output logic [stq_pkg::TIME_W-1:0]         head_time,
    output logic signed [stq_pkg::REPS_W-1:0]  head_repeats_left
);

    import stq_pkg::*;

    // Stored ids are the low bits of target_id, no wider than the port
    localparam int IdW  = (ID_BITS < TGT_W) ? ID_BITS : TGT_W;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam int PhW  = $clog2(QUEUE_DEPTH);

    state_t                    state_reg, state_next;
    cmd_t                      cmd_reg;
    logic [IdW-1:0]            key_target_reg;
    logic [TIME_W-1:0]         key_time_reg;
    logic signed [REPS_W-1:0]  key_reps_reg;
    logic [CntW-1:0]           count_reg, count_next;
    logic [PhW-1:0]            phase_reg, phase_next;
    logic                      found_reg, found_next;
    logic                      status_reg, status_next;

    logic                      out_valid_reg;
    logic                      status_out_reg;
    logic                      found_out_reg;
    logic [COUNT_W-1:0]        entry_count_reg;
    logic                      head_valid_reg;
    logic [TGT_W-1:0]          head_target_reg;
    logic [TIME_W-1:0]         head_time_reg;
    logic signed [REPS_W-1:0]  head_reps_reg;

    cell_ctrl_t                ctrl;
    logic                      in_accept;
    logic                      out_take;
    logic                      load_out;
    logic                      full;
    logic [CntW-1:0]           tally;

    // Per-cell views of the row
    logic [IdW-1:0]            cell_target [QUEUE_DEPTH];
    logic [TIME_W-1:0]         cell_time   [QUEUE_DEPTH];
    logic signed [REPS_W-1:0]  cell_reps   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]    keep_vec;
    logic [QUEUE_DEPTH-1:0]    match_vec;
    logic [QUEUE_DEPTH-1:0]    take_vec;
    logic [QUEUE_DEPTH:0]      keep_ext;

    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign full      = (count_reg == CntW'(QUEUE_DEPTH));

    // ---------------------------------------------------------------
    // Cell row. Each cell sees its two neighbors plus the shared key and count; cell 0 is the head.
    // The low end reads the key on insert, the high end sees an empty
    // neighbor during compaction.
    // ---------------------------------------------------------------
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic [IdW-1:0]            p_target, n_target;
        logic [TIME_W-1:0]         p_time, n_time;
        logic signed [REPS_W-1:0]  p_reps, n_reps;
        logic                      p_keep, p_take, n_keep;

        if (i == 0)
        begin : g_first
            assign p_target = key_target_reg;
            assign p_time   = key_time_reg;
            assign p_reps   = key_reps_reg;
            assign p_keep   = 1'b1;
            assign p_take   = 1'b0;
        end
        else
        begin : g_inner_lo
            assign p_target = cell_target[i-1];
            assign p_time   = cell_time[i-1];
            assign p_reps   = cell_reps[i-1];
            assign p_keep   = keep_vec[i-1];
            assign p_take   = take_vec[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign n_target = key_target_reg;
            assign n_time   = key_time_reg;
            assign n_reps   = key_reps_reg;
            assign n_keep   = 1'b0;
        end
        else
        begin : g_inner_hi
            assign n_target = cell_target[i+1];
            assign n_time   = cell_time[i+1];
            assign n_reps   = cell_reps[i+1];
            assign n_keep   = keep_vec[i+1];
        end

        stq_cell #(
            .Index (i),
            .IdW   (IdW),
            .CntW  (CntW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .count       (count_reg),
            .key_target  (key_target_reg),
            .key_time    (key_time_reg),
            .key_reps    (key_reps_reg),
            .prev_target (p_target),
            .prev_time   (p_time),
            .prev_reps   (p_reps),
            .prev_keep   (p_keep),
            .prev_take   (p_take),
            .next_target (n_target),
            .next_time   (n_time),
            .next_reps   (n_reps),
            .next_keep   (n_keep),
            .cell_target (cell_target[i]),
            .cell_time   (cell_time[i]),
            .cell_reps   (cell_reps[i]),
            .keep        (keep_vec[i]),
            .match       (match_vec[i]),
            .take        (take_vec[i])
        );
    end

    // After compaction the kept words form a run from cell 0; the new count
    // is the position of the run's upper edge.
    assign keep_ext = {1'b0, keep_vec};

    always_comb
    begin
        tally = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (keep_ext[i] && !keep_ext[i+1])
            begin
                tally = tally | CntW'(i + 1);
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: mark matches, execute, compact and tally (delete only), deliver.
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        phase_next  = phase_reg;
        found_next  = found_reg;
        status_next = status_reg;
        ctrl.op     = CELL_HOLD;
        ctrl.phase  = phase_reg[0];
        in_stall    = 1'b1;
        load_out    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = ST_MARK;
                end
            end
            ST_MARK:
            begin
                ctrl.op    = CELL_MARK;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                // found reflects the contents before the command
                found_next  = |match_vec;
                status_next = 1'b0;
                state_next  = ST_DONE;
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (full)
                        begin
                            status_next = 1'b1;
                        end
                        else
                        begin
                            ctrl.op    = CELL_INSERT;
                            count_next = count_reg + CntW'(1);
                        end
                    end
                    CMD_DELETE:
                    begin
                        phase_next = '0;
                        state_next = ST_SWAP;
                    end
                    CMD_CONTAINS:
                    begin
                    end
                    CMD_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SWAP:
            begin
                // one odd-even transposition step per cycle, QUEUE_DEPTH steps
                ctrl.op    = CELL_SWAP;
                phase_next = phase_reg + PhW'(1);
                if (phase_reg == PhW'(QUEUE_DEPTH - 1))
                begin
                    state_next = ST_TALLY;
                end
            end
            ST_TALLY:
            begin
                count_next = tally;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            phase_reg     <= '0;
            found_reg     <= 1'b0;
            status_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            phase_reg  <= phase_next;
            found_reg  <= found_next;
            status_reg <= status_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the command word; repeats are stored as requested minus one
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg        <= cmd_t'(command);
            key_target_reg <= target_id[IdW-1:0];
            key_time_reg   <= due_time;
            key_reps_reg   <= $signed({1'b0, repeat_count} - REPS_W'(1));
        end
    end

    // Result word; head fields read as zero on an empty queue
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_out_reg  <= status_reg;
            found_out_reg   <= found_reg;
            entry_count_reg <= COUNT_W'(count_reg);
            head_valid_reg  <= (count_reg != '0);
            if (count_reg != '0)
            begin
                head_target_reg <= TGT_W'(cell_target[0]);
                head_time_reg   <= cell_time[0];
                head_reps_reg   <= cell_reps[0];
            end
            else
            begin
                head_target_reg <= '0;
                head_time_reg   <= '0;
                head_reps_reg   <= '0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_out_reg;
    assign found             = found_out_reg;
    assign entry_count       = entry_count_reg;
    assign head_valid        = head_valid_reg;
    assign head_target       = head_target_reg;
    assign head_time         = head_time_reg;
    assign head_repeats_left = head_reps_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_accept_marks: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_MARK))
        else $error("accepted word did not start the mark step");

    a_compacted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TALLY) |-> ((keep_vec & (keep_vec + QUEUE_DEPTH'(1))) == '0))
        else $error("kept entries not packed at the head after compaction");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && cmd_reg == CMD_INSERT && full)
            |=> (status_reg && count_reg == $past(count_reg)))
        else $error("insert into a full queue changed the count");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result word raised outside the deliver step");
`endif

endmodule
